// ===== rtl/core/gaussian_blur_5x5_window_top_assert.svh =====
// Assertion macros for the 5x5 blur window block.
// Included by the top level and the result queue; clocked on aclk, reset by aresetn.
`ifndef GAUSSIAN_BLUR_5X5_WINDOW_TOP_ASSERT_SVH
`define GAUSSIAN_BLUR_5X5_WINDOW_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define GBW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define GBW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define GBW_ASSERT(label, prop, msg)
`define GBW_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/gbw_pkg.sv =====
// Shared types, constants and arithmetic helpers for the 5x5 blur window block.
// No dependencies.
package gbw_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    localparam int PIX_W     = 8;
    localparam int CHANNELS  = 3;
    localparam int RGB_W     = PIX_W * CHANNELS;
    localparam int LINES     = 4;
    localparam int LINE_W    = RGB_W * LINES;
    localparam int TAPS      = 5;
    localparam int DIM_W     = 12;
    localparam int COORD_W   = 11;
    localparam int CFG_IDX_W = 4;

    localparam int VSUM_W = 12;
    localparam int HSUM_W = 15;

    localparam int              RECIP_SHIFT = 22;
    localparam int              RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;

    localparam int MIN_DIM    = 5;
    localparam int EMIT_START = 4;
    localparam int CENTER_OFS = 2;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;

    localparam int FIFO_DEPTH = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 4'd0,
        REG_IMAGE_HEIGHT = 4'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
        logic [PIX_W-1:0]   red;
        logic [PIX_W-1:0]   green;
        logic [PIX_W-1:0]   blue;
        logic               frame_last;
    } result_t;

    // 1 2 4 2 1 weighted sum of five 8-bit samples
    function automatic logic [VSUM_W-1:0] vsum5(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] c,
                                                input logic [PIX_W-1:0] d,
                                                input logic [PIX_W-1:0] e);
        return VSUM_W'(a) + (VSUM_W'(b) << 1) + (VSUM_W'(c) << 2)
             + (VSUM_W'(d) << 1) + VSUM_W'(e);
    endfunction

    function automatic logic [HSUM_W-1:0] hsum5(input logic [VSUM_W-1:0] a,
                                                input logic [VSUM_W-1:0] b,
                                                input logic [VSUM_W-1:0] c,
                                                input logic [VSUM_W-1:0] d,
                                                input logic [VSUM_W-1:0] e);
        return HSUM_W'(a) + (HSUM_W'(b) << 1) + (HSUM_W'(c) << 2)
             + (HSUM_W'(d) << 1) + HSUM_W'(e);
    endfunction

    // exact floor(x / 100) for x < 25600 via reciprocal multiply
    function automatic logic [PIX_W-1:0] div100(input logic [HSUM_W-1:0] x);
        logic [HSUM_W+RECIP_W-1:0] prod;
        prod = (HSUM_W+RECIP_W)'(x) * (HSUM_W+RECIP_W)'(RECIP_100);
        return prod[RECIP_SHIFT +: PIX_W];
    endfunction

endpackage

// ===== rtl/core/gbw_line_store.sv =====
// Line store: four previous rows packed per column, registered read.
// Depends on gbw_pkg.
module gbw_line_store
    import gbw_pkg::*;
#(
    parameter int DEPTH  = MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(MAX_WIDTH_DEF)
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [LINE_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [LINE_W-1:0] wr_data
);

    logic [LINE_W-1:0] line_mem [DEPTH];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/gbw_result_fifo.sv =====
// Result queue between the blur pipeline and the output channel.
// Depends on gbw_pkg and the assertion macro header.
`include "gaussian_blur_5x5_window_top_assert.svh"
module gbw_result_fifo
    import gbw_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    head_valid,
    output result_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    `GBW_ASSERT_IMPL(a_fifo_no_overflow, push && !pop, 32'(count_reg) < DEPTH, "result queue overflow")
    `GBW_ASSERT_IMPL(a_fifo_no_underflow, pop, count_reg != '0, "result queue underflow")

endmodule

// ===== rtl/core/gaussian_blur_5x5_window_top.sv =====
// Top level of the 5x5 1-2-4-2-1 weighted blur over a raster BGR pixel stream.
// Depends on gbw_pkg, gbw_line_store, gbw_result_fifo and the assertion macro header.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_in_blue, s_in_green, s_in_red
//  m_      | out       | m_valid / m_ready  | m_center_row/col, m_out_blue/green/red,
//          |           |                    | m_frame_last
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One pixel request per cycle while s_ready is high; each result passes through the line
// store read, vertical sum, horizontal sum and divide into the result queue.
// The line store is one read port and one write port; a column is read on accept and
// written back the next cycle. s_ready drops only when the result queue has no room
// for requests already in flight. Reset clears positions, pending count and valid flags;
// the line store holds garbage until filled and needs no clearing pass.
`include "gaussian_blur_5x5_window_top_assert.svh"
module gaussian_blur_5x5_window_top
    import gbw_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [PIX_W-1:0]     s_in_blue,
    input  logic [PIX_W-1:0]     s_in_green,
    input  logic [PIX_W-1:0]     s_in_red,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COORD_W-1:0]   m_center_row,
    output logic [COORD_W-1:0]   m_center_col,
    output logic [PIX_W-1:0]     m_out_blue,
    output logic [PIX_W-1:0]     m_out_green,
    output logic [PIX_W-1:0]     m_out_red,
    output logic                 m_frame_last,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);
    localparam int PEND_W = $clog2(FIFO_DEPTH + 1);

    // configuration
    logic [DIM_W-1:0] cfg_width_reg, cfg_height_reg;
    logic             cfg_fire, cfg_hit;
    logic [WEFF_W-1:0] w_eff;
    logic [HEFF_W-1:0] h_eff;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    // only a mapped register restarts the frame
    assign cfg_hit   = cfg_fire
                    && ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= WIDTH_RST;
            cfg_height_reg <= HEIGHT_RST;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(cfg_width_reg) < MIN_DIM) begin
            w_eff = WEFF_W'(MIN_DIM);
        end else if (32'(cfg_width_reg) > MAX_WIDTH) begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end else begin
            w_eff = WEFF_W'(cfg_width_reg);
        end
        if (32'(cfg_height_reg) < MIN_DIM) begin
            h_eff = HEFF_W'(MIN_DIM);
        end else if (32'(cfg_height_reg) > MAX_HEIGHT) begin
            h_eff = HEFF_W'(MAX_HEIGHT);
        end else begin
            h_eff = HEFF_W'(cfg_height_reg);
        end
    end

    // position counters and accept
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              s_fire, col_end, row_end, emit_now, last_now;
    logic [PEND_W-1:0] pend_cnt_reg, pend_cnt_next;
    logic              m_fire;

    assign s_ready  = (32'(pend_cnt_reg) < FIFO_DEPTH);
    assign s_fire   = s_valid && s_ready;
    assign col_end  = (32'(col_reg) == 32'(w_eff) - 1);
    assign row_end  = (32'(row_reg) == 32'(h_eff) - 1);
    assign emit_now = (32'(col_reg) >= EMIT_START) && (32'(row_reg) >= EMIT_START);
    assign last_now = col_end && row_end;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (s_fire) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb begin
        pend_cnt_next = pend_cnt_reg;
        if ((s_fire && emit_now) && !m_fire) begin
            pend_cnt_next = pend_cnt_reg + 1'b1;
        end else if (!(s_fire && emit_now) && m_fire) begin
            pend_cnt_next = pend_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            pend_cnt_reg <= '0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    // stage 1: line store data returns, write back shifted column
    logic               s1_valid_reg, s1_emit_reg, s1_last_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [COORD_W-1:0] s1_crow_reg, s1_ccol_reg;
    logic [RGB_W-1:0]   s1_pix_reg;
    logic [LINE_W-1:0]  line_rd_data, line_wr_data;
    logic               line_clash;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_col_reg  <= col_reg;
            s1_pix_reg  <= {s_in_red, s_in_green, s_in_blue};
            s1_emit_reg <= emit_now;
            s1_last_reg <= last_now;
            s1_crow_reg <= COORD_W'(32'(row_reg) - CENTER_OFS);
            s1_ccol_reg <= COORD_W'(32'(col_reg) - CENTER_OFS);
        end
    end

    assign line_wr_data = {s1_pix_reg, line_rd_data[LINE_W-1:RGB_W]};
    assign line_clash   = s_fire && s1_valid_reg && (col_reg == s1_col_reg);

    gbw_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (s_fire),
        .rd_addr (col_reg),
        .rd_data (line_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr_data)
    );

    // vertical sums per column, shifted along the row
    logic [CHANNELS-1:0][VSUM_W-1:0] vsum_new;
    logic [CHANNELS-1:0][VSUM_W-1:0] vsum_reg [TAPS];

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            vsum_new[ch] = vsum5(line_rd_data[0*RGB_W + ch*PIX_W +: PIX_W],
                                 line_rd_data[1*RGB_W + ch*PIX_W +: PIX_W],
                                 line_rd_data[2*RGB_W + ch*PIX_W +: PIX_W],
                                 line_rd_data[3*RGB_W + ch*PIX_W +: PIX_W],
                                 s1_pix_reg[ch*PIX_W +: PIX_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            for (int t = 0; t < TAPS - 1; t++) begin
                vsum_reg[t] <= vsum_reg[t+1];
            end
            vsum_reg[TAPS-1] <= vsum_new;
        end
    end

    // stage 2: horizontal sum
    logic               s2_valid_reg, s2_last_reg;
    logic [COORD_W-1:0] s2_crow_reg, s2_ccol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_last_reg <= s1_last_reg;
            s2_crow_reg <= s1_crow_reg;
            s2_ccol_reg <= s1_ccol_reg;
        end
    end

    // stage 3: divide by 100 into the result queue
    logic                            s3_valid_reg, s3_last_reg;
    logic [COORD_W-1:0]              s3_crow_reg, s3_ccol_reg;
    logic [CHANNELS-1:0][HSUM_W-1:0] s3_hsum_reg;
    result_t                         push_data, head_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            s3_last_reg <= s2_last_reg;
            s3_crow_reg <= s2_crow_reg;
            s3_ccol_reg <= s2_ccol_reg;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                s3_hsum_reg[ch] <= hsum5(vsum_reg[0][ch], vsum_reg[1][ch], vsum_reg[2][ch],
                                         vsum_reg[3][ch], vsum_reg[4][ch]);
            end
        end
    end

    always_comb begin
        push_data.center_row = s3_crow_reg;
        push_data.center_col = s3_ccol_reg;
        push_data.blue       = div100(s3_hsum_reg[0]);
        push_data.green      = div100(s3_hsum_reg[1]);
        push_data.red        = div100(s3_hsum_reg[2]);
        push_data.frame_last = s3_last_reg;
    end

    assign m_fire = m_valid && m_ready;

    gbw_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_result_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s3_valid_reg),
        .push_data  (push_data),
        .pop        (m_fire),
        .head_valid (m_valid),
        .head_data  (head_data)
    );

    assign m_center_row = head_data.center_row;
    assign m_center_col = head_data.center_col;
    assign m_out_blue   = head_data.blue;
    assign m_out_green  = head_data.green;
    assign m_out_red    = head_data.red;
    assign m_frame_last = head_data.frame_last;

    `GBW_ASSERT(a_pend_bounded, 32'(pend_cnt_reg) <= FIFO_DEPTH, "pending results exceed queue")
    `GBW_ASSERT(a_no_line_clash, !line_clash, "line store read and write on one column")
    `GBW_ASSERT(a_col_in_frame, 32'(col_reg) < 32'(w_eff), "column outside frame")
    `GBW_ASSERT(a_row_in_frame, 32'(row_reg) < 32'(h_eff), "row outside frame")
    `GBW_ASSERT_IMPL(a_out_has_pending, m_valid, pend_cnt_reg != '0, "no pending count")

endmodule
